// ===== hdl/rsq_pkg.sv =====
package rsq_pkg;

  localparam int MsgBits  = 64;
  localparam int TimeBits = 32;
  localparam int FillBits = 4;

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  localparam logic [TimeBits-1:0] TIMEOUT_RESET = 32'd5000;

  typedef struct packed {
    logic                operation;
    logic [MsgBits-1:0]  message_word;
    logic [TimeBits-1:0] now_ms;
    logic                link_connected;
    logic                ack_received;
  } rsq_in_t;

  typedef struct packed {
    logic                send_valid;
    logic [MsgBits-1:0]  send_word;
    logic                push_refused;
    logic                head_advanced;
    logic [FillBits-1:0] fill_level;
  } rsq_out_t;

endpackage

// ===== hdl/retry_send_queue.sv =====
// Latency: one result per transaction, on res_o with done_o high in the cycle after start.
// Throughput: one transaction per cycle; busy stays low, the ring read port is registered
//   and forwards a word written to the head slot in the same cycle.
// Reset (rst_ni low, asynchronous): ring empty, no send or retry pending, stamp zero,
//   timeout 5000 ms. Ring contents are not cleared.
// Results cannot be stalled by the receiver; done_o is a one-cycle strobe.
module retry_send_queue
  import rsq_pkg::*;
#(
  parameter int RING_DEPTH    = 16,
  parameter int MESSAGE_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rsq_in_t             in_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TimeBits-1:0] cfg_data_i,
  output logic                done_o,
  output rsq_out_t            res_o
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int FW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FULL_LVL = FW'(RING_DEPTH - 1);

  logic [MESSAGE_WIDTH-1:0] ring_mem [RING_DEPTH];
  logic [MESSAGE_WIDTH-1:0] rd_q;

  logic [IW-1:0]       wr_q, wr_d, rd_idx_q, rd_idx_d;
  logic                send_pend_q, send_pend_d;
  logic                retry_pend_q, retry_pend_d;
  logic [TimeBits-1:0] stamp_q, stamp_d;
  logic [TimeBits-1:0] timeout_q;
  logic                done_q;
  rsq_out_t            res_q, res_d;

  logic          accept;
  logic          wr_en;
  logic [FW-1:0] fill_now, fill_next;
  logic          empty;

  function automatic logic [FW-1:0] fill_of(logic [IW-1:0] w, logic [IW-1:0] r);
    if (w >= r) return {1'b0, w} - {1'b0, r};
    else        return {1'b0, w} + FW'(RING_DEPTH) - {1'b0, r};
  endfunction

  function automatic logic [IW-1:0] next_idx(logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign fill_now    = fill_of(wr_q, rd_idx_q);
  assign empty       = (wr_q == rd_idx_q);

  always_comb begin
    logic sp;
    sp           = send_pend_q;
    wr_d         = wr_q;
    rd_idx_d     = rd_idx_q;
    send_pend_d  = send_pend_q;
    retry_pend_d = retry_pend_q;
    stamp_d      = stamp_q;
    wr_en        = 1'b0;
    res_d        = '0;
    if (accept) begin
      if (in_i.operation == OP_PUSH) begin
        if (fill_now >= FULL_LVL) begin
          res_d.push_refused = 1'b1;
        end else begin
          wr_en = 1'b1;
          wr_d  = next_idx(wr_q);
        end
      end else if (in_i.link_connected) begin
        if (!empty) begin
          if (send_pend_q || retry_pend_q) begin
            res_d.send_valid = 1'b1;
            res_d.send_word  = MsgBits'(rd_q);
            stamp_d          = in_i.now_ms;
            sp               = 1'b0;
            send_pend_d      = 1'b0;
            retry_pend_d     = 1'b0;
          end else if ((in_i.now_ms - stamp_q) > timeout_q) begin
            retry_pend_d = 1'b1;
            stamp_d      = in_i.now_ms;
          end
        end
        // ack counts even in the step that just sent the head
        if (in_i.ack_received && !sp && !empty) begin
          rd_idx_d            = next_idx(rd_idx_q);
          send_pend_d         = 1'b1;
          retry_pend_d        = 1'b0;
          res_d.head_advanced = 1'b1;
        end
      end
    end
    fill_next        = fill_of(wr_d, rd_idx_d);
    res_d.fill_level = FillBits'(fill_next);
  end

  // read port follows the next head index; forward a write into that slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_q] <= in_i.message_word[MESSAGE_WIDTH-1:0];
    end
    if (wr_en && (wr_q == rd_idx_d)) begin
      rd_q <= in_i.message_word[MESSAGE_WIDTH-1:0];
    end else begin
      rd_q <= ring_mem[rd_idx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q         <= '0;
      rd_idx_q     <= '0;
      send_pend_q  <= 1'b0;
      retry_pend_q <= 1'b0;
      stamp_q      <= '0;
      timeout_q    <= TIMEOUT_RESET;
      done_q       <= 1'b0;
    end else begin
      wr_q         <= wr_d;
      rd_idx_q     <= rd_idx_d;
      send_pend_q  <= send_pend_d;
      retry_pend_q <= retry_pend_d;
      stamp_q      <= stamp_d;
      done_q       <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_now < FW'(RING_DEPTH))
    else $error("ring fill out of range");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.push_refused && (res_o.send_valid || res_o.head_advanced)))
    else $error("push refusal mixed with process result");

  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.operation == OP_PUSH) && (fill_now < FULL_LVL) |=> !res_o.push_refused)
    else $error("push refused with room in ring");

  a_advance_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_d.head_advanced |=> (rd_idx_q != $past(rd_idx_q)) && send_pend_q)
    else $error("head advance did not move read index");

  a_send_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_d.send_valid && !res_d.head_advanced |=> !send_pend_q && !retry_pend_q)
    else $error("pending flags not cleared after send");

endmodule
